### src/ac3fap_pkg.sv
// Package: shared types and constants for the AC-3 frame attribute parser.
`default_nettype none
package ac3fap_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        logic        header_ok;
        logic        changed;
        logic        attr_valid;
        logic        is_enhanced;
        logic        dolby_surround;
        logic [4:0]  stream_id;
        logic [2:0]  service_mode;
        logic [2:0]  coding_mode;
        logic [15:0] sample_rate;
        logic [7:0]  dvb_type_code;
    } t_out_item;

    // Bit-walker command from top level to walker.
    typedef struct packed {
        logic clear;
        logic shift_bit;
        logic bit_val;
    } t_walk_ctrl;

    localparam logic [7:0]  SYNC_HI   = 8'h0B;
    localparam logic [7:0]  SYNC_LO   = 8'h77;
    localparam logic [4:0]  BSID_MAX  = 5'd10;
    localparam logic [15:0] RATE_48K  = 16'd48000;
    localparam logic [15:0] RATE_44K  = 16'd44100;
    localparam logic [15:0] RATE_32K  = 16'd32000;
    localparam logic [15:0] RATE_24K  = 16'd24000;
    localparam logic [15:0] RATE_22K  = 16'd22050;
    localparam logic [15:0] RATE_16K  = 16'd16000;
    localparam logic [7:0]  CT_ENH    = 8'h80;
    localparam logic [7:0]  CT_FULL   = 8'h40;

    function automatic logic [15:0] rate_of(input logic [1:0] fscod,
                                             input logic [1:0] fscod2,
                                             input logic enh);
        logic [15:0] r;
        r = 16'd0;
        case (fscod)
            2'd0: r = RATE_48K;
            2'd1: r = RATE_44K;
            2'd2: r = RATE_32K;
            default: begin
                if (enh) begin
                    case (fscod2)
                        2'd0: r = RATE_24K;
                        2'd1: r = RATE_22K;
                        2'd2: r = RATE_16K;
                        default: r = 16'd0;
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] component_of(input logic enh, input logic sur,
                                                 input logic [2:0] bsmod,
                                                 input logic [2:0] acmod);
        logic [7:0] c;
        c = enh ? CT_ENH : 8'h00;
        if (bsmod < 3'd2 || (bsmod == 3'd7 && acmod > 3'd1)) c = c | CT_FULL;
        c = c | {2'b00, bsmod, 3'b000};
        if (acmod == 3'd0) c = c | 8'd1;
        else if (acmod == 3'd2) c = c | (sur ? 8'd3 : 8'd2);
        else if (acmod > 3'd2) c = c | 8'd4;
        return c;
    endfunction

endpackage
`default_nettype wire

### src/ac3_frame_attribute_parser.sv
// Top level: AC-3 / E-AC-3 sync frame attribute parser.
// Takes one sync frame a byte at a time (frame_last on its final byte). Bytes 0..1
// are checked against the syncword 0x0B77, bytes 4..6 are kept as the header, and
// from byte 2 on every bit is fed MSB first, one bit per clock, into a serial walker
// that finds bsmod of E-AC-3 frames. The accepting edge loads a byte into the shift
// register, which then shifts it out bit by bit (bytes 0 and 1 likewise); input
// stall is high while the shift register drains, so no new byte is taken before
// the last is shifted out, and stays high through the commit step that follows the
// final byte: it compares and commits the attributes and loads the output register.
// A result still waiting in the output register holds the commit step of the next
// frame's last byte, and the input stays stalled until that result is taken.
`default_nettype none
module ac3_frame_attribute_parser (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  ac3fap_pkg::t_in_item   i_data,
    output logic                   o_valid,
    input  wire                    i_stall,
    output ac3fap_pkg::t_out_item  o_data
);
    import ac3fap_pkg::*;

    // Byte shift register and bit counter.
    logic [7:0]  r_shift;
    logic [3:0]  r_bits;       // bits left to shift
    logic        r_last;       // current byte is the frame's last
    logic        r_walk;       // current byte goes to the walker
    logic        r_commit;     // commit step pending
    logic [2:0]  r_pos;
    logic        r_sync;
    logic [7:0]  r_hdr [3];
    logic        r_held_valid;
    logic [28:0] r_held;
    logic        r_ovalid;
    t_out_item   r_out;
    t_walk_ctrl  walk_ctrl;
    logic [2:0]  found_mode;
    logic        accept;
    logic        busy;

    assign busy    = (r_bits != 4'd0) || r_commit;
    assign o_stall = busy;
    assign accept  = i_valid && !busy;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Feed one bit per cycle; clear the walker with the commit step.
    assign walk_ctrl.shift_bit = (r_bits != 4'd0) && r_walk;
    assign walk_ctrl.bit_val   = r_shift[7];
    assign walk_ctrl.clear     = r_commit && !(r_ovalid && i_stall);

    ac3fap_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (walk_ctrl),
        .o_found_mode(found_mode)
    );

    // Commit step: decode header, compare against held attributes.
    logic [4:0]  bsid;
    logic        enh, sur, ok, chg;
    logic [2:0]  bsmod, acmod;
    logic [15:0] rate;
    logic [28:0] attr;
    logic        hv_n;
    logic [28:0] held_n;

    always_comb begin
        bsid  = r_hdr[1][7:3];
        enh   = bsid > BSID_MAX;
        rate  = rate_of(r_hdr[0][7:6], r_hdr[0][5:4], enh);
        if (enh) begin
            bsmod = found_mode;
            acmod = r_hdr[0][3:1];
            sur   = 1'b0;
        end else begin
            bsmod = r_hdr[1][2:0];
            acmod = r_hdr[2][7:5];
            sur   = (acmod == 3'd2) && (r_hdr[2][4:3] == 2'd2);
        end
        attr   = {rate, acmod, bsmod, bsid, sur, enh};
        ok     = (r_pos == 3'd7) && r_sync;
        chg    = ok && (!r_held_valid || attr != r_held);
        hv_n   = r_held_valid || chg;
        held_n = chg ? attr : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 4'd0; r_commit <= 1'b0; r_pos <= 3'd0; r_sync <= 1'b0;
            r_held_valid <= 1'b0; r_held <= '0; r_ovalid <= 1'b0;
            r_last <= 1'b0; r_walk <= 1'b0;
        end else begin
            // Raise valid on commit; drop it once the result is taken.
            if (walk_ctrl.clear) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            if (accept) begin
                // Check sync and keep header bytes; advance byte position.
                if (r_pos == 3'd0) r_sync <= (i_data.data_byte == SYNC_HI);
                else if (r_pos == 3'd1) r_sync <= r_sync && (i_data.data_byte == SYNC_LO);
                if (r_pos >= 3'd4 && r_pos <= 3'd6)
                    r_hdr[2'(r_pos - 3'd4)] <= i_data.data_byte;
                if (r_pos != 3'd7) r_pos <= r_pos + 3'd1;
                r_shift <= i_data.data_byte;
                r_bits  <= 4'd8;
                r_walk  <= (r_pos >= 3'd2);
                r_last  <= i_data.frame_last;
            end else if (r_bits != 4'd0) begin
                r_shift <= {r_shift[6:0], 1'b0};
                r_bits  <= r_bits - 4'd1;
                if (r_bits == 4'd1 && r_last) r_commit <= 1'b1;
            end else if (walk_ctrl.clear) begin
                // Load the result and drop per-frame state.
                r_commit     <= 1'b0;
                r_held_valid <= hv_n;
                r_held       <= held_n;
                r_pos        <= 3'd0;
                r_sync       <= 1'b0;
                r_out.header_ok      <= ok;
                r_out.changed        <= chg;
                r_out.attr_valid     <= hv_n;
                r_out.is_enhanced    <= hv_n & held_n[0];
                r_out.dolby_surround <= hv_n & held_n[1];
                r_out.stream_id      <= hv_n ? held_n[6:2] : 5'd0;
                r_out.service_mode   <= hv_n ? held_n[9:7] : 3'd0;
                r_out.coding_mode    <= hv_n ? held_n[12:10] : 3'd0;
                r_out.sample_rate    <= hv_n ? held_n[28:13] : 16'd0;
                r_out.dvb_type_code  <= hv_n ? component_of(held_n[0], held_n[1],
                                        held_n[9:7], held_n[12:10]) : 8'd0;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits != 4'd0) |-> !accept)
        else $error("byte accepted while shifting");
    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_ctrl.clear |=> o_valid && r_pos == 3'd0)
        else $error("commit did not load the result");
    a_held_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |=> r_held_valid)
        else $error("held attributes lost");

endmodule
`default_nettype wire

### src/ac3fap_walker.sv
// Bit-serial walker over the E-AC-3 bitstream-info fields, one bit per cycle while shift_bit is high.
`default_nettype none
module ac3fap_walker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ac3fap_pkg::t_walk_ctrl  i_ctrl,
    output logic [2:0]              o_found_mode
);
    import ac3fap_pkg::*;

    typedef enum logic [5:0] {
        PH_ST0, PH_ST1, PH_FS0, PH_FS1, PH_NB0, PH_NB1, PH_AC0, PH_AC1, PH_AC2,
        PH_LFE, PH_COMPRE, PH_COMPR2E, PH_CHANMAPE, PH_MIXMDATE, PH_LFEMIXE,
        PH_PGMSCLE, PH_PGMSCL2E, PH_EXTPGMSCLE, PH_MIXDEF0, PH_MIXDEF1,
        PH_MIXLEN0, PH_MIXLEN1, PH_MIXLEN2, PH_MIXLEN3, PH_MIXLEN4,
        PH_PANE, PH_PAN2E, PH_FRMMIXE, PH_BLKE, PH_INFOMDATE,
        PH_BSM0, PH_BSM1, PH_BSM2, PH_DONE
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [8:0] r_skip, n_skip;
    logic [4:0] r_acc, n_acc;
    logic [1:0] r_kind, n_kind;
    logic [2:0] r_acmod, n_acmod;
    logic       r_lfe, n_lfe;
    logic [1:0] r_blk, n_blk;
    logic [2:0] r_bidx, n_bidx;
    logic [2:0] r_mode, n_mode;
    logic       b;
    logic [2:0] bcount;
    logic [1:0] acc2;

    assign b = i_ctrl.bit_val;
    assign o_found_mode = r_mode;
    assign acc2 = {r_acc[0], b};

    always_comb begin
        case (r_blk)
            2'd0: bcount = 3'd1;
            2'd1: bcount = 3'd2;
            2'd2: bcount = 3'd3;
            default: bcount = 3'd6;
        endcase
    end

    always_comb begin
        n_phase = r_phase; n_skip = r_skip; n_acc = r_acc; n_kind = r_kind;
        n_acmod = r_acmod; n_lfe = r_lfe; n_blk = r_blk; n_bidx = r_bidx;
        n_mode = r_mode;
        if (r_skip != 9'd0) begin
            n_skip = r_skip - 9'd1;
        end else begin
            unique case (r_phase)
                PH_ST0: begin n_kind = {b, 1'b0}; n_phase = PH_ST1; end
                PH_ST1: begin
                    n_kind = {r_kind[1], b}; n_skip = 9'd14; n_phase = PH_FS0;
                end
                PH_FS0: begin n_acc = {4'd0, b}; n_phase = PH_FS1; end
                PH_FS1: begin
                    n_acc = {3'd0, acc2};
                    if (acc2 == 2'd3) begin
                        n_skip = 9'd2; n_blk = 2'd3; n_phase = PH_AC0;
                    end else n_phase = PH_NB0;
                end
                PH_NB0: begin n_blk = {b, 1'b0}; n_phase = PH_NB1; end
                PH_NB1: begin n_blk = {r_blk[1], b}; n_phase = PH_AC0; end
                PH_AC0: begin n_acmod = {b, 2'b00}; n_phase = PH_AC1; end
                PH_AC1: begin n_acmod = {r_acmod[2], b, 1'b0}; n_phase = PH_AC2; end
                PH_AC2: begin n_acmod = {r_acmod[2:1], b}; n_phase = PH_LFE; end
                PH_LFE: begin n_lfe = b; n_skip = 9'd10; n_phase = PH_COMPRE; end
                PH_COMPRE: begin
                    n_skip = b ? 9'd8 : 9'd0;
                    if (r_acmod == 3'd0) begin
                        n_skip = n_skip + 9'd5; n_phase = PH_COMPR2E;
                    end else n_phase = (r_kind == 2'd1) ? PH_CHANMAPE : PH_MIXMDATE;
                end
                PH_COMPR2E: begin
                    if (b) n_skip = 9'd8;
                    n_phase = (r_kind == 2'd1) ? PH_CHANMAPE : PH_MIXMDATE;
                end
                PH_CHANMAPE: begin if (b) n_skip = 9'd16; n_phase = PH_MIXMDATE; end
                PH_MIXMDATE: begin
                    if (!b) n_phase = PH_INFOMDATE;
                    else begin
                        if (r_acmod > 3'd2) n_skip = n_skip + 9'd2;
                        if (r_acmod[0] && r_acmod > 3'd2) n_skip = n_skip + 9'd6;
                        if (r_acmod[2]) n_skip = n_skip + 9'd6;
                        if (r_lfe) n_phase = PH_LFEMIXE;
                        else n_phase = (r_kind == 2'd0) ? PH_PGMSCLE : PH_INFOMDATE;
                    end
                end
                PH_LFEMIXE: begin
                    if (b) n_skip = 9'd5;
                    n_phase = (r_kind == 2'd0) ? PH_PGMSCLE : PH_INFOMDATE;
                end
                PH_PGMSCLE: begin
                    if (b) n_skip = 9'd6;
                    n_phase = (r_acmod == 3'd0) ? PH_PGMSCL2E : PH_EXTPGMSCLE;
                end
                PH_PGMSCL2E: begin if (b) n_skip = 9'd6; n_phase = PH_EXTPGMSCLE; end
                PH_EXTPGMSCLE: begin if (b) n_skip = 9'd6; n_phase = PH_MIXDEF0; end
                PH_MIXDEF0: begin n_acc = {4'd0, b}; n_phase = PH_MIXDEF1; end
                PH_MIXDEF1: begin
                    n_acc = {3'd0, acc2};
                    if (acc2 == 2'd3) begin
                        n_acc = 5'd0; n_phase = PH_MIXLEN0;
                    end else begin
                        if (acc2 == 2'd1) n_skip = 9'd5;
                        else if (acc2 == 2'd2) n_skip = 9'd12;
                        n_phase = (r_acmod < 3'd2) ? PH_PANE : PH_FRMMIXE;
                    end
                end
                PH_MIXLEN0, PH_MIXLEN1, PH_MIXLEN2, PH_MIXLEN3: begin
                    n_acc = {r_acc[3:0], b};
                    n_phase = t_phase'(r_phase + 6'd1);
                end
                PH_MIXLEN4: begin
                    n_acc = {r_acc[3:0], b};
                    n_skip = {1'b0, n_acc, 3'b000} + 9'd16;
                    n_phase = (r_acmod < 3'd2) ? PH_PANE : PH_FRMMIXE;
                end
                PH_PANE: begin
                    if (b) n_skip = 9'd14;
                    n_phase = (r_acmod == 3'd0) ? PH_PAN2E : PH_FRMMIXE;
                end
                PH_PAN2E: begin if (b) n_skip = 9'd14; n_phase = PH_FRMMIXE; end
                PH_FRMMIXE: begin
                    if (!b) n_phase = PH_INFOMDATE;
                    else if (r_blk == 2'd0) begin
                        n_skip = 9'd5; n_phase = PH_INFOMDATE;
                    end else begin
                        n_bidx = 3'd0; n_phase = PH_BLKE;
                    end
                end
                PH_BLKE: begin
                    if (b) n_skip = 9'd5;
                    n_bidx = r_bidx + 3'd1;
                    if (n_bidx >= bcount) n_phase = PH_INFOMDATE;
                end
                PH_INFOMDATE: n_phase = b ? PH_BSM0 : PH_DONE;
                PH_BSM0: begin n_acc = {4'd0, b}; n_phase = PH_BSM1; end
                PH_BSM1: begin n_acc = {2'd0, r_acc[1:0], b}; n_phase = PH_BSM2; end
                PH_BSM2: begin n_mode = {r_acc[1:0], b}; n_phase = PH_DONE; end
                default: n_phase = PH_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_phase <= PH_ST0; r_skip <= '0; r_acc <= '0; r_kind <= '0;
            r_acmod <= '0; r_lfe <= 1'b0; r_blk <= '0; r_bidx <= '0; r_mode <= '0;
        end else if (i_ctrl.shift_bit) begin
            r_phase <= n_phase; r_skip <= n_skip; r_acc <= n_acc; r_kind <= n_kind;
            r_acmod <= n_acmod; r_lfe <= n_lfe; r_blk <= n_blk; r_bidx <= n_bidx;
            r_mode <= n_mode;
        end
    end

    a_mode_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.shift_bit && !i_ctrl.clear && r_phase != PH_BSM2)
        |=> $stable(r_mode) || $past(i_ctrl.clear) == 1'b0 && r_mode == 3'd0
        || $stable(r_mode))
        else $error("bsmod changed outside its last bit");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctrl.shift_bit && !i_ctrl.clear) |=> $stable(r_phase) && $stable(r_skip))
        else $error("walker advanced without a bit");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> r_phase == PH_ST0 && r_skip == 9'd0 && r_mode == 3'd0)
        else $error("walker not cleared");

endmodule
`default_nettype wire
